[rtl/core/periodic_timer_bank_tick_core_assert.svh]
`ifndef PERIODIC_TIMER_BANK_TICK_CORE_ASSERT_SVH
`define PERIODIC_TIMER_BANK_TICK_CORE_ASSERT_SVH
// check a condition implies another on the same edge
`define PTB_ASSERT_IMP(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("assertion failed");
// check a condition implies another on the next edge
`define PTB_ASSERT_NEXT(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("assertion failed");
`endif

[rtl/core/ptbt_pkg.sv]
`default_nettype none
package ptbt_pkg;
	localparam int unsigned CMD_W     = 3;
	localparam int unsigned SLOT_W    = 5;
	localparam int unsigned ELAPSED_W = 24;
	localparam int unsigned PERIOD_W  = 48;
	localparam int unsigned LIMIT_W   = 32;
	localparam int unsigned COUNT_W   = 40;
	localparam int unsigned ACC_W     = PERIOD_W + 1;
	localparam int unsigned MAX_REPORTS = 32;

	typedef enum logic [CMD_W-1:0] {
		CMD_TICK      = 3'd0,
		CMD_CONFIGURE = 3'd1,
		CMD_ENABLE    = 3'd2,
		CMD_REMOVE    = 3'd3,
		CMD_CLR_NCORE = 3'd4,
		CMD_GLOBAL_EN = 3'd5,
		CMD_CLR_ALL   = 3'd6,
		CMD_NONE      = 3'd7
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_START,
		ST_DIV,
		ST_WRITE,
		ST_EMIT,
		ST_ACK
	} state_t;
endpackage
`default_nettype wire

[rtl/core/ptbt_divider.sv]
`default_nettype none
module ptbt_divider #(
	parameter int unsigned ACC_W = 49,
	parameter int unsigned DEN_W = 48
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   start,
	input  wire  [ACC_W-1:0]      dividend,
	input  wire  [DEN_W-1:0]      divisor,
	output logic                  busy,
	output logic                  done,
	output logic [ACC_W-1:0]      quotient,
	output logic [DEN_W-1:0]      remainder
);
	localparam int unsigned CNT_W = $clog2(ACC_W + 1);

	logic [CNT_W-1:0] count_q;
	logic [ACC_W-1:0] quo_q;
	logic [DEN_W:0]   rem_q;
	logic [DEN_W-1:0] den_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   shifted;
	logic [DEN_W:0]   diff;
	logic             ge;

	assign shifted = {rem_q[DEN_W-1:0], quo_q[ACC_W-1]};
	assign diff    = shifted - {1'b0, den_q};
	assign ge      = shifted >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			count_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q  <= 1'b1;
				count_q <= CNT_W'(ACC_W);
			end else if (busy_q) begin
				count_q <= count_q - 1'b1;
				if (count_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[ACC_W-2:0], ge};
			rem_q <= ge ? diff : shifted;
		end
	end

	assign busy      = busy_q;
	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q[DEN_W-1:0];
endmodule
`default_nettype wire

[rtl/core/periodic_timer_bank_tick_core.sv]
// channel | signals                                              | dir
// request | in_valid in_stall command slot elapsed_us period ... | in
// result  | out_valid out_stall fired fired_slot fire_count ...  | out
// A tick walks every slot: one 49-step restoring division per running
// slot, between the read, start and write states.
// Other commands pass through the ACK state. One request is in work at a time.
// Reset clears flags and sets global enable; values need no reset.
// A stalled result holds the walk until it is taken.
`default_nettype none
`include "periodic_timer_bank_tick_core_assert.svh"
module periodic_timer_bank_tick_core #(
	parameter int unsigned NUM_SLOTS = 32,
	parameter int unsigned FRAC_BITS = 16
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              in_valid,
	output logic                             in_stall,
	input  wire  [ptbt_pkg::CMD_W-1:0]       command,
	input  wire  [ptbt_pkg::SLOT_W-1:0]      slot,
	input  wire  [ptbt_pkg::ELAPSED_W-1:0]   elapsed_us,
	input  wire  [ptbt_pkg::PERIOD_W-1:0]    period,
	input  wire  [ptbt_pkg::LIMIT_W-1:0]     fire_limit,
	input  wire                              keep_in_core,
	input  wire                              count_only,
	input  wire                              flag_value,
	output logic                             out_valid,
	input  wire                              out_stall,
	output logic                             fired,
	output logic [ptbt_pkg::SLOT_W-1:0]      fired_slot,
	output logic [ptbt_pkg::COUNT_W-1:0]     fire_count,
	output logic                             is_counter,
	output logic                             last
);
	localparam int unsigned IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int unsigned WALK_W = $clog2(NUM_SLOTS + 1);
	localparam int unsigned PW = ptbt_pkg::PERIOD_W;
	localparam int unsigned AW = ptbt_pkg::ACC_W;
	localparam int unsigned RPT_W = $clog2(ptbt_pkg::MAX_REPORTS + 1);

	logic [NUM_SLOTS-1:0] valid_q, enabled_q, core_q, ctr_q;
	logic                 gen_q;
	logic [PW-1:0]                   period_mem [NUM_SLOTS];
	logic [ptbt_pkg::LIMIT_W-1:0]    limit_mem  [NUM_SLOTS];
	logic [PW-1:0]                   acc_mem    [NUM_SLOTS];

	ptbt_pkg::state_t state_q, state_d;
	logic [ptbt_pkg::ELAPSED_W-1:0] elapsed_q;
	logic [WALK_W-1:0]              idx_q;
	logic [RPT_W-1:0]               nrep_q;
	logic [PW-1:0]                  per_rd_q, acc_rd_q;
	logic [ptbt_pkg::LIMIT_W-1:0]   lim_rd_q;
	logic [ptbt_pkg::COUNT_W-1:0]   cnt_q;
	logic                           ovalid_q, ofired_q, octr_q, olast_q;
	logic [ptbt_pkg::SLOT_W-1:0]    oslot_q;
	logic [ptbt_pkg::COUNT_W-1:0]   ocount_q;
	logic                           pend_q, pctr_q;
	logic [ptbt_pkg::SLOT_W-1:0]    pslot_q;
	logic [ptbt_pkg::COUNT_W-1:0]   pcount_q;

	logic          div_start, div_busy, div_done;
	logic [AW-1:0] div_quo;
	logic [PW-1:0] div_rem;
	logic [PW-1:0] per_eff;
	logic [AW-1:0] acc_sum;
	logic [IDX_W-1:0] idx;
	logic          running, at_end, out_free, emit_now, take_rep;
	logic [AW-1:0] cnt_lim;
	logic [ptbt_pkg::COUNT_W-1:0] cnt_sat;

	assign idx      = idx_q[IDX_W-1:0];
	assign at_end   = idx_q == WALK_W'(NUM_SLOTS);
	assign running  = !at_end && valid_q[idx] && enabled_q[idx] && (core_q[idx] || gen_q);
	assign out_free = !ovalid_q || !out_stall;
	assign per_eff  = (per_rd_q == '0) ? PW'(1) << FRAC_BITS : per_rd_q;
	assign acc_sum  = {1'b0, acc_rd_q} + (AW'(elapsed_q) << FRAC_BITS);
	assign in_stall = state_q != ptbt_pkg::ST_IDLE;

	always_comb begin
		cnt_lim = div_quo;
		if (lim_rd_q != '0 && div_quo > AW'(lim_rd_q))
			cnt_lim = AW'(lim_rd_q);
		cnt_sat = (cnt_lim > AW'({ptbt_pkg::COUNT_W{1'b1}})) ?
			{ptbt_pkg::COUNT_W{1'b1}} : cnt_lim[ptbt_pkg::COUNT_W-1:0];
	end

	ptbt_divider #(.ACC_W(AW), .DEN_W(PW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(acc_sum),
		.divisor(per_eff), .busy(div_busy), .done(div_done),
		.quotient(div_quo), .remainder(div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ptbt_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		emit_now  = 1'b0;
		take_rep  = 1'b0;
		unique case (state_q)
			ptbt_pkg::ST_IDLE: begin
				if (in_valid)
					state_d = (ptbt_pkg::cmd_t'(command) == ptbt_pkg::CMD_TICK) ?
						ptbt_pkg::ST_READ : ptbt_pkg::ST_ACK;
			end
			ptbt_pkg::ST_READ: begin
				if (at_end)
					state_d = ptbt_pkg::ST_EMIT;
				else if (running)
					state_d = ptbt_pkg::ST_START;
			end
			ptbt_pkg::ST_START: begin
				div_start = 1'b1;
				state_d   = ptbt_pkg::ST_DIV;
			end
			ptbt_pkg::ST_DIV: begin
				if (div_done)
					state_d = ptbt_pkg::ST_WRITE;
			end
			ptbt_pkg::ST_WRITE: begin
				if (cnt_q == '0 || nrep_q == RPT_W'(ptbt_pkg::MAX_REPORTS))
					state_d = ptbt_pkg::ST_READ;
				else if (!pend_q || out_free) begin
					take_rep = 1'b1;
					emit_now = pend_q;
					state_d  = ptbt_pkg::ST_READ;
				end
			end
			ptbt_pkg::ST_EMIT: begin
				if (out_free) begin
					emit_now = 1'b1;
					state_d  = ptbt_pkg::ST_IDLE;
				end
			end
			ptbt_pkg::ST_ACK: begin
				if (out_free) begin
					emit_now = 1'b1;
					state_d  = ptbt_pkg::ST_IDLE;
				end
			end
			default: state_d = ptbt_pkg::ST_IDLE;
		endcase
	end

	// flags and walk control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			enabled_q <= '0;
			core_q    <= '0;
			ctr_q     <= '0;
			gen_q     <= 1'b1;
			idx_q     <= '0;
			nrep_q    <= '0;
			ovalid_q  <= 1'b0;
			olast_q   <= 1'b0;
			ofired_q  <= 1'b0;
			pend_q    <= 1'b0;
		end else begin
			ovalid_q <= emit_now || (ovalid_q && out_stall);
			if (state_q == ptbt_pkg::ST_IDLE && in_valid) begin
				idx_q  <= '0;
				nrep_q <= '0;
				if (32'(slot) < NUM_SLOTS) begin
					unique case (ptbt_pkg::cmd_t'(command))
						ptbt_pkg::CMD_CONFIGURE: begin
							valid_q[slot[IDX_W-1:0]]   <= 1'b1;
							enabled_q[slot[IDX_W-1:0]] <= 1'b1;
							core_q[slot[IDX_W-1:0]]    <= keep_in_core;
							ctr_q[slot[IDX_W-1:0]]     <= count_only;
						end
						ptbt_pkg::CMD_ENABLE: begin
							if (valid_q[slot[IDX_W-1:0]])
								enabled_q[slot[IDX_W-1:0]] <= flag_value;
						end
						ptbt_pkg::CMD_REMOVE: begin
							valid_q[slot[IDX_W-1:0]]   <= 1'b0;
							enabled_q[slot[IDX_W-1:0]] <= 1'b0;
							core_q[slot[IDX_W-1:0]]    <= 1'b0;
							ctr_q[slot[IDX_W-1:0]]     <= 1'b0;
						end
						default: ;
					endcase
				end
				unique case (ptbt_pkg::cmd_t'(command))
					ptbt_pkg::CMD_CLR_NCORE: begin
						gen_q     <= 1'b0;
						valid_q   <= valid_q & core_q;
						enabled_q <= enabled_q & core_q;
						ctr_q     <= ctr_q & core_q;
					end
					ptbt_pkg::CMD_GLOBAL_EN: gen_q <= flag_value;
					ptbt_pkg::CMD_CLR_ALL: begin
						valid_q   <= '0;
						enabled_q <= '0;
						core_q    <= '0;
						ctr_q     <= '0;
					end
					default: ;
				endcase
			end
			if (state_q == ptbt_pkg::ST_READ && !at_end && !running)
				idx_q <= idx_q + 1'b1;
			if (state_q == ptbt_pkg::ST_WRITE && state_d == ptbt_pkg::ST_READ)
				idx_q <= idx_q + 1'b1;
			if (take_rep) begin
				nrep_q <= nrep_q + 1'b1;
				pend_q <= 1'b1;
			end else if (state_q == ptbt_pkg::ST_EMIT && emit_now) begin
				pend_q <= 1'b0;
			end
			if (emit_now) begin
				ofired_q <= pend_q;
				olast_q  <= state_q != ptbt_pkg::ST_WRITE;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ptbt_pkg::ST_IDLE && in_valid) begin
			elapsed_q <= elapsed_us;
			if (ptbt_pkg::cmd_t'(command) == ptbt_pkg::CMD_CONFIGURE &&
			    32'(slot) < NUM_SLOTS) begin
				period_mem[slot[IDX_W-1:0]] <= period;
				limit_mem[slot[IDX_W-1:0]]  <= fire_limit;
				acc_mem[slot[IDX_W-1:0]]    <= '0;
			end
		end
		if (state_q == ptbt_pkg::ST_READ && !at_end) begin
			per_rd_q <= period_mem[idx];
			lim_rd_q <= limit_mem[idx];
			acc_rd_q <= acc_mem[idx];
		end
		if (state_q == ptbt_pkg::ST_DIV && div_done) begin
			acc_mem[idx] <= div_rem;
			cnt_q        <= cnt_sat;
		end
		// hold the newest report back so the final one can carry last
		if (take_rep) begin
			pslot_q  <= ptbt_pkg::SLOT_W'(idx_q);
			pcount_q <= cnt_q;
			pctr_q   <= ctr_q[idx];
		end
		if (emit_now) begin
			oslot_q  <= pend_q ? pslot_q : '0;
			ocount_q <= pend_q ? pcount_q : '0;
			octr_q   <= pend_q ? pctr_q : 1'b0;
		end
	end

	assign out_valid  = ovalid_q;
	assign fired      = ofired_q;
	assign fired_slot = ofired_q ? oslot_q : '0;
	assign fire_count = ofired_q ? ocount_q : '0;
	assign is_counter = ofired_q ? octr_q : 1'b0;
	assign last       = olast_q;

	`PTB_ASSERT_IMP(a_no_accept_busy, clk, arst_n,
		state_q != ptbt_pkg::ST_IDLE, in_stall)
	`PTB_ASSERT_IMP(a_div_only_walk, clk, arst_n,
		div_busy, state_q == ptbt_pkg::ST_DIV)
	`PTB_ASSERT_NEXT(a_start_busy, clk, arst_n,
		div_start, div_busy)
endmodule
`default_nettype wire
